>>> sv/clt_pkg.sv
// Shared types, character codes and token kinds for the token lexer.
// No dependencies; imported by every module of the lexer.
package clt_pkg;

    localparam int OFFSET_WIDTH_DEF = 24;
    localparam int LINE_WIDTH_DEF   = 20;
    localparam int COLUMN_WIDTH_DEF = 16;

    localparam int TOK_OFF_W  = 24;
    localparam int TOK_LEN_W  = 16;
    localparam int TOK_LINE_W = 20;
    localparam int TOK_COL_W  = 16;
    localparam int FILE_W     = 16;
    localparam int KIND_W     = 5;

    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_IDENT  = 3'd1;
    localparam logic [2:0] M_SLASH  = 3'd2;
    localparam logic [2:0] M_LINE   = 3'd3;
    localparam logic [2:0] M_BLOCK  = 3'd4;
    localparam logic [2:0] M_BSTAR  = 3'd5;
    localparam logic [2:0] M_STRING = 3'd6;
    localparam logic [2:0] M_ESC    = 3'd7;

    localparam logic [4:0] K_DIVIDE    = 5'd16;
    localparam logic [4:0] K_INTEGER   = 5'd26;
    localparam logic [4:0] K_MACRO     = 5'd27;
    localparam logic [4:0] K_STRING    = 5'd28;
    localparam logic [4:0] K_IDENT     = 5'd29;
    localparam logic [4:0] K_MACRO_END = 5'd30;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [TOK_OFF_W-1:0]  start;
        logic [TOK_LEN_W-1:0]  len;
        logic [TOK_LINE_W-1:0] line;
        logic [TOK_COL_W-1:0]  col;
        logic                  eol;
        logic                  unterm;
        logic                  bad;
    } t_tok;

    typedef struct packed {
        logic [1:0]       cnt;
        t_tok [2:0]       tok;
    } t_batch;

    // punctuation mark to kind; bit 5 set when the byte is a mark
    function automatic logic [5:0] punct_kind(input logic [7:0] b);
        logic [5:0] r;
        r = 6'd0;
        case (b)
            8'h5B: r = {1'b1, 5'd0};
            8'h5D: r = {1'b1, 5'd1};
            8'h3C: r = {1'b1, 5'd2};
            8'h3E: r = {1'b1, 5'd3};
            8'h7B: r = {1'b1, 5'd4};
            8'h7D: r = {1'b1, 5'd5};
            8'h28: r = {1'b1, 5'd6};
            8'h29: r = {1'b1, 5'd7};
            8'h2B: r = {1'b1, 5'd8};
            8'h2D: r = {1'b1, 5'd9};
            8'h2A: r = {1'b1, 5'd10};
            8'h25: r = {1'b1, 5'd11};
            8'h5E: r = {1'b1, 5'd12};
            8'h3F: r = {1'b1, 5'd13};
            8'h3A: r = {1'b1, 5'd14};
            8'h7E: r = {1'b1, 5'd15};
            8'h2F: r = {1'b1, 5'd16};
            8'h3D: r = {1'b1, 5'd17};
            8'h3B: r = {1'b1, 5'd18};
            8'h2E: r = {1'b1, 5'd19};
            8'h2C: r = {1'b1, 5'd20};
            8'h21: r = {1'b1, 5'd21};
            8'h26: r = {1'b1, 5'd22};
            8'h7C: r = {1'b1, 5'd23};
            8'h24: r = {1'b1, 5'd24};
            8'h40: r = {1'b1, 5'd25};
            default: r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic logic is_ident_start(input logic [7:0] b);
        return (b inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (b == CH_UNDER);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

endpackage

>>> sv/c_like_token_lexer.sv
// Streaming lexer for C-like text: one source byte per request in, tokens out.
// A finished token is held until a later token or the final byte pushes it out.
// Takes one byte per cycle while each byte yields at most one token and the output
// accepts it; a byte that yields two or three tokens holds the input until they drain.
// Reset (synchronous, active low) clears the scanner, held token and file_id.
module c_like_token_lexer #(
    parameter int OFFSET_WIDTH = clt_pkg::OFFSET_WIDTH_DEF,
    parameter int LINE_WIDTH   = clt_pkg::LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH = clt_pkg::COLUMN_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // text_byte
    input  logic        s_axis_tlast,  // is_final
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // start_offset[23:0], token_length[39:24], line_number[59:40],
    // column_number[75:60], file_number[91:76], ends_line[92],
    // string_unterminated[93], bad_character[94], zero[95]
    output logic [95:0] m_axis_tdata,
    output logic [4:0]  m_axis_tuser,  // token_kind
    output logic        m_axis_tlast,  // run_last
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    import clt_pkg::*;

    logic        take;
    logic        room;
    t_batch      batch;
    t_tok        tok;
    logic [FILE_W-1:0] r_file_id;

    assign s_axis_tready = room;
    assign take = s_axis_tvalid && room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_file_id <= '0;
        else if (i_cfg_we) r_file_id <= i_cfg_wdata;
    end

    clt_core #(
        .OFFSET_WIDTH(OFFSET_WIDTH),
        .LINE_WIDTH  (LINE_WIDTH),
        .COLUMN_WIDTH(COLUMN_WIDTH)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (take),
        .i_byte (s_axis_tdata),
        .i_final(s_axis_tlast),
        .o_batch(batch)
    );

    clt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take),
        .i_batch (batch),
        .i_tready(m_axis_tready),
        .o_room  (room),
        .o_tvalid(m_axis_tvalid),
        .o_tok   (tok),
        .o_tlast (m_axis_tlast)
    );

    assign m_axis_tuser = tok.kind;
    assign m_axis_tdata = {1'b0, tok.bad, tok.unterm, tok.eol, r_file_id,
                           tok.col, tok.line, tok.len, tok.start};

endmodule

>>> sv/clt_core.sv
// Scanner state and per-byte token logic of the lexer.
// Produces up to three finished tokens per byte. Depends on clt_pkg.
module clt_core #(
    parameter int OFFSET_WIDTH = clt_pkg::OFFSET_WIDTH_DEF,
    parameter int LINE_WIDTH   = clt_pkg::LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH = clt_pkg::COLUMN_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic [7:0]     i_byte,
    input  logic           i_final,
    output clt_pkg::t_batch o_batch
);
    import clt_pkg::*;

    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX  = '1;
    localparam logic [LINE_WIDTH-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_WIDTH-1:0] COL_MAX  = '1;

    logic [2:0]              r_mode, n_mode;
    logic [OFFSET_WIDTH-1:0] r_off, n_off, r_os, n_os;
    logic [LINE_WIDTH-1:0]   r_ln, n_ln, r_ol, n_ol;
    logic [COLUMN_WIDTH-1:0] r_cl, n_cl, r_oc, n_oc;
    logic [TOK_LEN_W-1:0]    r_olen, n_olen;
    logic                    r_mac, n_mac;
    t_tok                    r_held, n_held;
    logic                    r_hv, n_hv;

    logic [2:0] a_v;
    t_tok [2:0] a_t;
    logic       mark_eol;
    logic [5:0] pk;
    logic       idle;
    logic [1:0] cnt;
    t_tok [2:0] toks;

    function automatic t_tok mk(input logic [4:0] kind, input logic [OFFSET_WIDTH-1:0] st,
                                input logic [TOK_LEN_W-1:0] len,
                                input logic [LINE_WIDTH-1:0] ln,
                                input logic [COLUMN_WIDTH-1:0] cl,
                                input logic unterm, input logic bad);
        t_tok t;
        logic [OFFSET_WIDTH+TOK_OFF_W-1:0]  so;
        logic [LINE_WIDTH+TOK_LINE_W-1:0]   sl;
        logic [COLUMN_WIDTH+TOK_COL_W-1:0]  sc;
        so = {{TOK_OFF_W{1'b0}}, st};
        sl = {{TOK_LINE_W{1'b0}}, ln};
        sc = {{TOK_COL_W{1'b0}}, cl};
        t.kind   = kind;
        t.start  = so[TOK_OFF_W-1:0];
        t.len    = len;
        t.line   = sl[TOK_LINE_W-1:0];
        t.col    = sc[TOK_COL_W-1:0];
        t.eol    = 1'b0;
        t.unterm = unterm;
        t.bad    = bad;
        return t;
    endfunction

    always_comb begin
        n_mode = r_mode; n_off = r_off; n_ln = r_ln; n_cl = r_cl; n_mac = r_mac;
        n_os = r_os; n_ol = r_ol; n_oc = r_oc; n_olen = r_olen;
        n_held = r_held; n_hv = r_hv;
        a_v = 3'b000;
        a_t = '0;
        mark_eol = 1'b0;
        idle = 1'b0;
        cnt = 2'd0;
        toks = '0;
        pk = punct_kind(i_byte);

        // mode step; offset/column advance inline with saturation
        case (r_mode)
            M_IDENT: begin
                if (is_ident_start(i_byte) || is_digit(i_byte)) begin
                    if (n_olen != '1) n_olen = n_olen + 1'b1;
                    if (n_off != OFF_MAX) n_off = n_off + 1'b1;
                    if (n_cl != COL_MAX) n_cl = n_cl + 1'b1;
                end else begin
                    a_v[0] = 1'b1;
                    a_t[0] = mk(K_IDENT, r_os, r_olen, r_ol, r_oc, 1'b0, 1'b0);
                    n_mode = M_IDLE;
                    idle = 1'b1;
                end
            end
            M_SLASH: begin
                if (i_byte == CH_SLASH || i_byte == CH_STAR) begin
                    if (n_off != OFF_MAX) n_off = n_off + 1'b1;
                    if (n_cl != COL_MAX) n_cl = n_cl + 1'b1;
                    n_mode = (i_byte == CH_SLASH) ? M_LINE : M_BLOCK;
                end else begin
                    a_v[0] = 1'b1;
                    a_t[0] = mk(K_DIVIDE, r_os, r_olen, r_ol, r_oc, 1'b0, 1'b0);
                    n_mode = M_IDLE;
                    idle = 1'b1;
                end
            end
            M_LINE: begin
                if (i_byte == CH_LF || i_byte == CH_CR) begin
                    n_mode = M_IDLE;
                    idle = 1'b1;
                end else begin
                    if (n_off != OFF_MAX) n_off = n_off + 1'b1;
                    if (n_cl != COL_MAX) n_cl = n_cl + 1'b1;
                end
            end
            M_BLOCK, M_BSTAR: begin
                if (n_off != OFF_MAX) n_off = n_off + 1'b1;
                if (n_cl != COL_MAX) n_cl = n_cl + 1'b1;
                if (i_byte == CH_STAR) n_mode = M_BSTAR;
                else if (r_mode == M_BSTAR && i_byte == CH_SLASH) n_mode = M_IDLE;
                else n_mode = M_BLOCK;
            end
            M_STRING, M_ESC: begin
                if (n_olen != '1) n_olen = n_olen + 1'b1;
                if (n_off != OFF_MAX) n_off = n_off + 1'b1;
                if (i_byte == CH_LF) begin
                    if (n_ln != LINE_MAX) n_ln = n_ln + 1'b1;
                    n_cl = '0;
                end else if (n_cl != COL_MAX) begin
                    n_cl = n_cl + 1'b1;
                end
                n_mode = M_STRING;
                if (r_mode == M_STRING) begin
                    if (i_byte == CH_BSL) n_mode = M_ESC;
                    else if (i_byte == CH_QUOTE) begin
                        a_v[0] = 1'b1;
                        a_t[0] = mk(K_STRING, r_os, n_olen, r_ol, r_oc, 1'b0, 1'b0);
                        n_mode = M_IDLE;
                    end
                end
            end
            default: idle = 1'b1;
        endcase

        if (idle) begin
            if (i_byte == CH_SPACE || i_byte == CH_TAB || i_byte == CH_CR
                || i_byte == CH_LF) begin
                if (n_off != OFF_MAX) n_off = n_off + 1'b1;
                if (n_cl != COL_MAX) n_cl = n_cl + 1'b1;
                if (i_byte == CH_LF) begin
                    if (n_mac) begin
                        n_mac = 1'b0;
                        a_v[1] = 1'b1;
                        a_t[1] = mk(K_MACRO_END, n_off, 16'd1, n_ln, n_cl, 1'b0, 1'b0);
                    end
                    mark_eol = 1'b1;
                    if (n_ln != LINE_MAX) n_ln = n_ln + 1'b1;
                    n_cl = '0;
                end
            end else if (i_byte == CH_SLASH || i_byte == CH_QUOTE
                         || is_ident_start(i_byte)) begin
                n_os = n_off; n_ol = n_ln; n_oc = n_cl; n_olen = 16'd1;
                if (n_off != OFF_MAX) n_off = n_off + 1'b1;
                if (n_cl != COL_MAX) n_cl = n_cl + 1'b1;
                if (i_byte == CH_SLASH) n_mode = M_SLASH;
                else if (i_byte == CH_QUOTE) n_mode = M_STRING;
                else n_mode = M_IDENT;
            end else begin
                a_v[1] = 1'b1;
                if (is_digit(i_byte))
                    a_t[1] = mk(K_INTEGER, n_off, 16'd1, n_ln, n_cl, 1'b0, 1'b0);
                else if (i_byte == CH_HASH) begin
                    n_mac = 1'b1;
                    a_t[1] = mk(K_MACRO, n_off, 16'd1, n_ln, n_cl, 1'b0, 1'b0);
                end else if (pk[5])
                    a_t[1] = mk(pk[4:0], n_off, 16'd1, n_ln, n_cl, 1'b0, 1'b0);
                else
                    a_t[1] = mk(K_IDENT, n_off, 16'd0, n_ln, n_cl, 1'b0, 1'b1);
                if (n_off != OFF_MAX) n_off = n_off + 1'b1;
                if (n_cl != COL_MAX) n_cl = n_cl + 1'b1;
            end
        end

        if (i_final) begin
            if (n_mode == M_IDENT || n_mode == M_SLASH) begin
                a_v[2] = 1'b1;
                a_t[2] = mk((n_mode == M_IDENT) ? K_IDENT : K_DIVIDE, n_os, n_olen,
                            n_ol, n_oc, 1'b0, 1'b0);
            end else if (n_mode == M_STRING || n_mode == M_ESC) begin
                a_v[2] = 1'b1;
                a_t[2] = mk(K_STRING, n_os, n_olen, n_ol, n_oc, 1'b1, 1'b0);
            end
        end

        // appends in order: each pushes out the held token
        for (int i = 0; i < 3; i++) begin
            if (a_v[i]) begin
                if (n_hv && cnt != 2'd3) begin
                    toks[cnt] = n_held;
                    cnt = cnt + 2'd1;
                end
                n_held = a_t[i];
                n_hv = 1'b1;
            end
            if (i == 1 && mark_eol && n_hv) n_held.eol = 1'b1;
        end

        if (i_final) begin
            if (n_hv && cnt != 2'd3) begin
                toks[cnt] = n_held;
                cnt = cnt + 2'd1;
            end
            n_mode = M_IDLE; n_off = '0; n_ln = '0; n_cl = '0; n_mac = 1'b0;
            n_os = '0; n_ol = '0; n_oc = '0; n_olen = '0;
            n_held = '0; n_hv = 1'b0;
        end
    end

    assign o_batch.cnt = cnt;
    assign o_batch.tok = toks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_off <= '0; r_ln <= '0; r_cl <= '0; r_mac <= 1'b0;
            r_os <= '0; r_ol <= '0; r_oc <= '0; r_olen <= '0;
            r_held <= '0; r_hv <= 1'b0;
        end else if (i_take) begin
            r_mode <= n_mode; r_off <= n_off; r_ln <= n_ln; r_cl <= n_cl; r_mac <= n_mac;
            r_os <= n_os; r_ol <= n_ol; r_oc <= n_oc; r_olen <= n_olen;
            r_held <= n_held; r_hv <= n_hv;
        end
    end

endmodule

>>> sv/clt_outq.sv
// Result register for one byte's batch of up to three tokens, drained in order.
// Depends on clt_pkg.
module clt_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  clt_pkg::t_batch i_batch,
    input  logic            i_tready,
    output logic            o_room,
    output logic            o_tvalid,
    output clt_pkg::t_tok   o_tok,
    output logic            o_tlast
);
    import clt_pkg::*;

    t_tok [2:0] r_tok;
    logic [1:0] r_left;
    logic [1:0] r_rd;

    assign o_tvalid = (r_left != 2'd0);
    assign o_tlast  = (r_left == 2'd1);
    assign o_tok    = r_tok[r_rd];
    assign o_room   = (r_left == 2'd0) || (r_left == 2'd1 && i_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
            r_rd   <= 2'd0;
        end else if (i_load) begin
            r_left <= i_batch.cnt;
            r_rd   <= 2'd0;
        end else if (o_tvalid && i_tready) begin
            r_left <= r_left - 2'd1;
            r_rd   <= r_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_tok <= i_batch.tok;
    end

endmodule
